FILE: rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared field widths and command codes for the forest tree counter.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int VTX_W  = 10;   // vertex fields, vertex count, tree count
    localparam int CASE_W = 16;   // case number

    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

endpackage

FILE: rtl/forest_tree_counter.sv
// ----------------------------------------------------------------------------
// forest_tree_counter
// Counts the acyclic connected components of an undirected graph built from
// edge beats, using union-find links and cycle marks held in one memory.
// ----------------------------------------------------------------------------
// edge beat: links followed from each end to its root, one store
//   read per link, plus a link write in S_LINK when two components merge
// finish beat: store swept one entry per cycle, then the result is registered
//   in S_DONE once any old result is taken; input ready rises with result valid
// reset: store is swept back to self links,
//   input ready stays low meanwhile; case number restarts at one
module forest_tree_counter #(
    parameter int MAX_VERTICES = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fct_pkg::VTX_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [fct_pkg::VTX_W-1:0]   i_first_vertex,
    input  logic [fct_pkg::VTX_W-1:0]   i_second_vertex,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fct_pkg::VTX_W-1:0]   o_tree_count,
    output logic [fct_pkg::CASE_W-1:0]  o_case_number,
    output logic                        o_bad_vertex_seen
);
    import fct_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = ((VW + 1) > VTX_W) ? (VW + 1) : VTX_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);

    logic [VTX_W-1:0] r_vertex_count;
    logic [CW-1:0]    eff_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VTX_W'(1);
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // counts above the store depth clamp to the depth
    assign eff_count = (CW'(r_vertex_count) > CNT_MAX) ? CNT_MAX : CW'(r_vertex_count);

    fct_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_eff_count       (eff_count),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_first_vertex    (i_first_vertex),
        .i_second_vertex   (i_second_vertex),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_tree_count      (o_tree_count),
        .o_case_number     (o_case_number),
        .o_bad_vertex_seen (o_bad_vertex_seen)
    );

    // a finish beat starts the sweep, so nothing else is taken next cycle
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_command == CMD_FINISH) |=> !o_in_ready)
        else $error("input taken right after a finish beat");

    // an edge naming vertex zero is dropped without a store walk
    a_bad_edge_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_command == CMD_EDGE && i_first_vertex == '0)
        |=> o_in_ready)
        else $error("bad edge started a root walk");

    // case numbering skips zero on wrap
    a_case_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_case_number != '0))
        else $error("case number zero emitted");

    // trees never outnumber the vertices in the case
    a_trees_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CW'(o_tree_count) <= eff_count))
        else $error("tree count above vertex count");

endmodule

FILE: rtl/fct_store.sv
// ----------------------------------------------------------------------------
// fct_store
// Single-port-write, single-port-read synchronous memory, registered read,
// read-first on an address collision.
// ----------------------------------------------------------------------------
module fct_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 10
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/fct_seq.sv
// ----------------------------------------------------------------------------
// fct_seq
// Union-find sequencer: walks root chains through the store, merges or marks
// components, and sweeps the store on finish to count acyclic roots.
// ----------------------------------------------------------------------------
module fct_seq #(
    parameter int MAX_VERTICES = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [$clog2(MAX_VERTICES)
                  + ((($clog2(MAX_VERTICES) + 1) > fct_pkg::VTX_W) ? 1
                     : (fct_pkg::VTX_W - $clog2(MAX_VERTICES))) - 1:0] i_eff_count,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [fct_pkg::VTX_W-1:0]   i_first_vertex,
    input  logic [fct_pkg::VTX_W-1:0]   i_second_vertex,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fct_pkg::VTX_W-1:0]   o_tree_count,
    output logic [fct_pkg::CASE_W-1:0]  o_case_number,
    output logic                        o_bad_vertex_seen
);
    import fct_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = ((VW + 1) > VTX_W) ? (VW + 1) : VTX_W;
    localparam logic [VW:0]     IDX_END = (VW + 1)'(MAX_VERTICES);
    localparam logic [CASE_W-1:0] CASE_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_FIND_A, S_FIND_B, S_LINK, S_SCAN, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [VW-1:0]     r_cur, n_cur;
    logic [VW-1:0]     r_b, n_b;
    logic [VW-1:0]     r_ra, n_ra;
    logic              r_ra_mark, n_ra_mark;
    logic [VW:0]       r_idx, n_idx;
    logic              r_chk, n_chk;
    logic [VW-1:0]     r_chk_idx, n_chk_idx;
    logic              r_emit, n_emit;
    logic [CW-1:0]     r_trees, n_trees;
    logic              r_err, n_err;
    logic [CASE_W-1:0] r_case, n_case;
    logic              r_out_valid, n_out_valid;
    logic [VTX_W-1:0]  r_out_trees, n_out_trees;
    logic [CASE_W-1:0] r_out_case, n_out_case;
    logic              r_out_bad, n_out_bad;

    logic [VW-1:0] rd_addr, wr_addr;
    logic [VW:0]   rd_data, wr_data;
    logic          wr_en;
    logic [VW-1:0] rd_link;
    logic          rd_mark;
    logic          bad_edge;
    logic [VW-1:0] a_idx, b_idx;

    fct_store #(
        .DEPTH (MAX_VERTICES),
        .AW    (VW),
        .DW    (VW + 1)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // entry layout: {cycle mark, root link}
    assign rd_mark = rd_data[VW];
    assign rd_link = rd_data[VW-1:0];

    assign bad_edge = (i_first_vertex == '0) || (i_second_vertex == '0)
                   || (CW'(i_first_vertex) > i_eff_count)
                   || (CW'(i_second_vertex) > i_eff_count);
    assign a_idx = VW'(i_first_vertex - VTX_W'(1));
    assign b_idx = VW'(i_second_vertex - VTX_W'(1));

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_b         = r_b;
        n_ra        = r_ra;
        n_ra_mark   = r_ra_mark;
        n_idx       = r_idx;
        n_chk       = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_emit      = r_emit;
        n_trees     = r_trees;
        n_err       = r_err;
        n_case      = r_case;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out_trees = r_out_trees;
        n_out_case  = r_out_case;
        n_out_bad   = r_out_bad;
        rd_addr     = r_cur;
        wr_en       = 1'b0;
        wr_addr     = r_cur;
        wr_data     = {1'b0, r_cur};

        // scan pipeline: entry read last cycle is checked now
        if (r_chk && r_emit && (rd_link == r_chk_idx) && !rd_mark
                && (CW'(r_chk_idx) < i_eff_count)) begin
            n_trees = r_trees + CW'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_FINISH) begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                        n_trees = '0;
                        n_emit  = 1'b1;
                    end else if (bad_edge) begin
                        n_err = 1'b1;
                    end else begin
                        rd_addr = a_idx;
                        n_cur   = a_idx;
                        n_b     = b_idx;
                        n_state = S_FIND_A;
                    end
                end
            end
            S_FIND_A: begin
                if (rd_link == r_cur) begin
                    n_ra      = r_cur;
                    n_ra_mark = rd_mark;
                    n_cur     = r_b;
                    rd_addr   = r_b;
                    n_state   = S_FIND_B;
                end else begin
                    n_cur   = rd_link;
                    rd_addr = rd_link;
                end
            end
            S_FIND_B: begin
                if (rd_link == r_cur) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cur;
                    if (r_cur == r_ra) begin
                        // same component: this edge closes a cycle
                        wr_data = {1'b1, r_cur};
                        n_state = S_IDLE;
                    end else begin
                        wr_data = {rd_mark | r_ra_mark, r_cur};
                        n_state = S_LINK;
                    end
                end else begin
                    n_cur   = rd_link;
                    rd_addr = rd_link;
                end
            end
            S_LINK: begin
                wr_en   = 1'b1;
                wr_addr = r_ra;
                wr_data = {r_ra_mark, r_cur};
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (r_idx != IDX_END) begin
                    // read old entry and restore it to a self link in one go
                    rd_addr   = r_idx[VW-1:0];
                    wr_en     = 1'b1;
                    wr_addr   = r_idx[VW-1:0];
                    wr_data   = {1'b0, r_idx[VW-1:0]};
                    n_idx     = r_idx + (VW + 1)'(1);
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx[VW-1:0];
                end else if (!r_chk) begin
                    n_state = r_emit ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_trees = r_trees[VTX_W-1:0];
                    n_out_case  = r_case;
                    n_out_bad   = r_err;
                    n_case      = (r_case == CASE_MAX) ? CASE_W'(1)
                                                       : r_case + CASE_W'(1);
                    n_err       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // reset runs the sweep without a result to rebuild the store
            r_state     <= S_SCAN;
            r_idx       <= '0;
            r_chk       <= 1'b0;
            r_emit      <= 1'b0;
            r_err       <= 1'b0;
            r_case      <= CASE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_chk       <= n_chk;
            r_emit      <= n_emit;
            r_err       <= n_err;
            r_case      <= n_case;
            r_out_valid <= n_out_valid;
        end
        r_cur       <= n_cur;
        r_b         <= n_b;
        r_ra        <= n_ra;
        r_ra_mark   <= n_ra_mark;
        r_chk_idx   <= n_chk_idx;
        r_trees     <= n_trees;
        r_out_trees <= n_out_trees;
        r_out_case  <= n_out_case;
        r_out_bad   <= n_out_bad;
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_tree_count      = r_out_trees;
    assign o_case_number     = r_out_case;
    assign o_bad_vertex_seen = r_out_bad;

endmodule
